// File: hdl/wps_pkg.sv
// Package: types, codes and constants shared by the WAVE stream parser files.
`default_nettype none

package wps_pkg;

  // Four-character tags as they sit in the little-endian shift word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;

  localparam logic [31:0] MIN_HEADER  = 32'd44;
  localparam logic [31:0] MIN_FMT_LEN = 32'd16;
  localparam logic [31:0] FACT_LEN    = 32'd4;
  localparam logic [15:0] PCM_FORMAT  = 16'd1;
  localparam logic [15:0] PCM_DEPTH   = 16'd16;
  localparam logic [15:0] MONO        = 16'd1;

  // Byte offsets where header fields complete.
  localparam int unsigned OFF_W = 6;
  localparam logic [OFF_W-1:0] OFF_START     = 6'd0;
  localparam logic [OFF_W-1:0] OFF_RIFF_TAG  = 6'd3;
  localparam logic [OFF_W-1:0] OFF_RIFF_LEN  = 6'd7;
  localparam logic [OFF_W-1:0] OFF_WAVE_TAG  = 6'd11;
  localparam logic [OFF_W-1:0] OFF_FMT_LEN   = 6'd19;
  localparam logic [OFF_W-1:0] OFF_FMT_CODE  = 6'd21;
  localparam logic [OFF_W-1:0] OFF_CHANNELS  = 6'd23;
  localparam logic [OFF_W-1:0] OFF_RATE      = 6'd27;
  localparam logic [OFF_W-1:0] OFF_ALIGN     = 6'd33;
  localparam logic [OFF_W-1:0] OFF_DEPTH     = 6'd35;
  localparam logic [OFF_W-1:0] OFF_CHUNK_TAG = 6'd3;
  localparam logic [OFF_W-1:0] OFF_CHUNK_LEN = 6'd7;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_FMT,
    PH_SKIP,
    PH_CHDR,
    PH_SAMP,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_SHORT     = 4'd0,
    ERR_RIFF      = 4'd1,
    ERR_WAVE      = 4'd2,
    ERR_RIFF_LEN  = 4'd3,
    ERR_PCM       = 4'd4,
    ERR_DEPTH     = 4'd5,
    ERR_CHANNELS  = 4'd6,
    ERR_FMT_LEN   = 4'd7,
    ERR_FACT      = 4'd8,
    ERR_TRUNCATED = 4'd9
  } err_e;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        end_of_buffer;
    logic [31:0] buffer_length;
  } wps_in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic [31:0]        rate;
    logic [31:0]        data_bytes;
    err_e               error_code;
    logic               is_last;
  } wps_out_t;

  // Parser state. data_remaining counts down the data length by the block
  // alignment of each sample, so no running sum has to be compared.
  typedef struct packed {
    phase_e           phase;
    logic [OFF_W-1:0] byte_offset;
    logic [31:0]      word_shift;
    logic [31:0]      chunk_tag;
    logic [31:0]      skip_remaining;
    logic [31:0]      saved_rate;
    logic [15:0]      saved_block_align;
    logic [31:0]      data_remaining;
    logic [7:0]       low_byte;
  } wps_state_t;

  localparam wps_state_t STATE_RESET = '{
    phase:             PH_RIFF,
    byte_offset:       '0,
    word_shift:        '0,
    chunk_tag:         '0,
    skip_remaining:    '0,
    saved_rate:        '0,
    saved_block_align: '0,
    data_remaining:    '0,
    low_byte:          '0
  };

endpackage

`default_nettype wire

// File: hdl/wps_step.sv
// Combinational parse step: next parser state and optional result for one byte.
`default_nettype none

module wps_step (
  input  wps_pkg::wps_state_t state_i,
  input  wps_pkg::wps_in_t    word_i,
  output wps_pkg::wps_state_t state_o,
  output logic                res_valid_o,
  output wps_pkg::wps_out_t   res_o
);
  import wps_pkg::*;

  wps_state_t  nxt;
  logic [31:0] ws;
  logic [31:0] skip_dec;
  logic [31:0] fmt_rest;
  logic [31:0] rem_dec;
  logic        failed;
  err_e        code;
  logic        last;

  assign ws       = {word_i.in_byte, state_i.word_shift[31:8]};
  assign skip_dec = state_i.skip_remaining - 32'd1;
  assign fmt_rest = state_i.skip_remaining - MIN_FMT_LEN;
  assign rem_dec  = state_i.data_remaining - {16'd0, state_i.saved_block_align};

  always_comb begin
    nxt         = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_FORMAT, sample: '0, rate: '0, data_bytes: '0,
                    error_code: ERR_SHORT, is_last: 1'b0};
    failed      = 1'b0;
    code        = ERR_SHORT;
    last        = 1'b0;

    if (state_i.phase == PH_DONE) begin
      if (word_i.end_of_buffer) begin
        nxt = STATE_RESET;
      end
    end else begin
      nxt.word_shift  = ws;
      nxt.byte_offset = state_i.byte_offset + OFF_W'(1);

      case (state_i.phase)
        PH_RIFF: begin
          if (state_i.byte_offset == OFF_START && word_i.buffer_length < MIN_HEADER) begin
            failed = 1'b1;
            code   = ERR_SHORT;
          end else if (state_i.byte_offset == OFF_RIFF_TAG && ws != TAG_RIFF) begin
            failed = 1'b1;
            code   = ERR_RIFF;
          end else if (state_i.byte_offset == OFF_RIFF_LEN) begin
            nxt.chunk_tag = ws;
          end else if (state_i.byte_offset == OFF_WAVE_TAG) begin
            if (ws != TAG_WAVE) begin
              failed = 1'b1;
              code   = ERR_WAVE;
            end else if (word_i.buffer_length < state_i.chunk_tag) begin
              failed = 1'b1;
              code   = ERR_RIFF_LEN;
            end else begin
              nxt.phase = PH_FMT;
            end
          end
        end
        PH_FMT: begin
          if (state_i.byte_offset == OFF_FMT_LEN) begin
            nxt.skip_remaining = ws;
          end else if (state_i.byte_offset == OFF_FMT_CODE) begin
            nxt.chunk_tag = {16'd0, ws[31:16]};
          end else if (state_i.byte_offset == OFF_CHANNELS) begin
            nxt.chunk_tag = {ws[31:16], state_i.chunk_tag[15:0]};
          end else if (state_i.byte_offset == OFF_RATE) begin
            nxt.saved_rate = ws;
          end else if (state_i.byte_offset == OFF_ALIGN) begin
            nxt.saved_block_align = ws[31:16];
          end else if (state_i.byte_offset == OFF_DEPTH) begin
            if (state_i.chunk_tag[15:0] != PCM_FORMAT) begin
              failed = 1'b1;
              code   = ERR_PCM;
            end else if (ws[31:16] != PCM_DEPTH) begin
              failed = 1'b1;
              code   = ERR_DEPTH;
            end else if (state_i.chunk_tag[31:16] != MONO) begin
              failed = 1'b1;
              code   = ERR_CHANNELS;
            end else if (state_i.skip_remaining < MIN_FMT_LEN) begin
              failed = 1'b1;
              code   = ERR_FMT_LEN;
            end else begin
              // Any extension bytes of the format chunk are skipped.
              nxt.skip_remaining = fmt_rest;
              nxt.byte_offset    = '0;
              nxt.phase          = (fmt_rest != 32'd0) ? PH_SKIP : PH_CHDR;
            end
          end
        end
        PH_SKIP: begin
          nxt.skip_remaining = skip_dec;
          if (skip_dec == 32'd0) begin
            nxt.byte_offset = '0;
            nxt.phase       = PH_CHDR;
          end
        end
        PH_CHDR: begin
          if (state_i.byte_offset == OFF_CHUNK_TAG) begin
            nxt.chunk_tag = ws;
          end else if (state_i.byte_offset >= OFF_CHUNK_LEN) begin
            nxt.byte_offset = '0;
            if (state_i.chunk_tag == TAG_DATA) begin
              last = (state_i.saved_block_align == 16'd0) ||
                     ({16'd0, state_i.saved_block_align} > ws);
              nxt.data_remaining = ws;
              nxt.phase          = last ? PH_DONE : PH_SAMP;
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_FORMAT;
              res_o.rate         = state_i.saved_rate;
              res_o.data_bytes   = ws;
              res_o.is_last      = last;
            end else if (state_i.chunk_tag == TAG_FACT && ws != FACT_LEN) begin
              failed = 1'b1;
              code   = ERR_FACT;
            end else begin
              nxt.skip_remaining = ws;
              nxt.phase          = (ws != 32'd0) ? PH_SKIP : PH_CHDR;
            end
          end
        end
        PH_SAMP: begin
          if (state_i.byte_offset == OFF_START) begin
            nxt.low_byte = word_i.in_byte;
          end else begin
            last = (state_i.saved_block_align == 16'd0) ||
                   ({16'd0, state_i.saved_block_align} > rem_dec);
            nxt.byte_offset    = '0;
            nxt.data_remaining = rem_dec;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_SAMPLE;
            res_o.sample       = {word_i.in_byte, state_i.low_byte};
            res_o.is_last      = last;
            if (last) begin
              nxt.phase = PH_DONE;
            end
          end
        end
        default: begin
          nxt = state_i;
        end
      endcase

      if (failed) begin
        nxt.phase        = PH_DONE;
        res_valid_o      = 1'b1;
        res_o            = '{kind: KIND_ERROR, sample: '0, rate: '0, data_bytes: '0,
                             error_code: code, is_last: 1'b1};
      end

      // The final byte resets the parser; an unfinished parse is a truncation.
      if (word_i.end_of_buffer) begin
        if (nxt.phase != PH_DONE) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_ERROR, sample: '0, rate: '0, data_bytes: '0,
                          error_code: ERR_TRUNCATED, is_last: 1'b1};
        end
        nxt = STATE_RESET;
      end
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// File: hdl/wav_pcm16_mono_stream_parser.sv
// Top level of the streaming RIFF/WAVE 16-bit mono PCM parser.
//
//   Channel  Direction  Handshake                Word
//   in       input      in_valid_i / in_stall_o  wps_in_t: in_byte, end_of_buffer,
//                                                buffer_length
//   out      output     out_valid_o / out_stall_i wps_out_t: kind, sample, rate,
//                                                data_bytes, error_code, is_last
//
// A word in the input register is parsed, and its result, if any, is captured in
// the output register; one word per cycle while the output is not stalled.
// The parser state register loops back through the combinational parse step.
// Reset clears the valid bits and returns the parser to expecting the RIFF header.
// An output stall holds the input register and raises in_stall_o; nothing is dropped.
`default_nettype none

module wav_pcm16_mono_stream_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wps_pkg::wps_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wps_pkg::wps_out_t out_word_o
);
  import wps_pkg::*;

  // Input register holding the next byte to parse.
  logic       in_valid_q;
  wps_in_t    in_q;

  // Parser state and output register.
  wps_state_t state_q;
  wps_state_t state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  wps_out_t   out_q;

  logic       step_res_valid;
  wps_out_t   step_res;
  logic       advance;

  // The held byte is parsed when the output register is free or is being
  // emptied in this same cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  wps_step u_step (
    .state_i     (state_q),
    .word_i      (in_q),
    .state_o     (state_d),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  // A result stays while stalled; a new one replaces it only once taken.
  assign out_valid_d = (advance && step_res_valid) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (advance && step_res_valid) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: tb/wave_parse_checker.sv
// Checker for the WAVE parser: predicts each result word and compares it with the output channel.
`timescale 1ns / 1ps

module wave_parse_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  wps_pkg::wps_in_t  in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  wps_pkg::wps_out_t out_word_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       format_seen_o,
  output int unsigned       sample_seen_o,
  output int unsigned       error_seen_o
);
  import wps_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Private copy of the parser state.
  phase_e      phase_q;
  logic [31:0] offset_q;
  logic [31:0] shift_q;
  logic [31:0] tag_q;
  logic [31:0] skip_q;
  logic [31:0] rate_q;
  logic [15:0] align_q;
  logic [31:0] data_len_q;
  logic [33:0] align_sum_q;
  logic [7:0]  low_q;

  wps_out_t    due_results[$];
  int unsigned fails;
  int unsigned formats;
  int unsigned samples;
  int unsigned errors;

  task automatic clear_parser();
    phase_q     = PH_RIFF;
    offset_q    = '0;
    shift_q     = '0;
    tag_q       = '0;
    skip_q      = '0;
    rate_q      = '0;
    align_q     = '0;
    data_len_q  = '0;
    align_sum_q = '0;
    low_q       = '0;
  endtask

  // True while another whole block alignment still fits in the data length.
  function automatic logic samples_left();
    return (align_q != 16'd0) && ((align_sum_q + align_q) <= data_len_q);
  endfunction

  function automatic wps_out_t error_word(err_e code);
    wps_out_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.is_last    = 1'b1;
    return r;
  endfunction

  task automatic parse_byte(input wps_in_t w, output logic got, output wps_out_t r);
    logic [31:0] off;
    logic        failed;
    logic        fin;
    err_e        code;
    got    = 1'b0;
    r      = '0;
    failed = 1'b0;
    code   = ERR_SHORT;
    if (phase_q == PH_DONE) begin
      if (w.end_of_buffer) clear_parser();
      return;
    end
    shift_q  = {w.in_byte, shift_q[31:8]};
    off      = offset_q;
    offset_q = off + 1;
    case (phase_q)
      PH_RIFF: begin
        if (off == OFF_START && w.buffer_length < MIN_HEADER) begin
          failed = 1'b1;
          code   = ERR_SHORT;
        end else if (off == OFF_RIFF_TAG && shift_q != TAG_RIFF) begin
          failed = 1'b1;
          code   = ERR_RIFF;
        end else if (off == OFF_RIFF_LEN) begin
          tag_q = shift_q;
        end else if (off == OFF_WAVE_TAG) begin
          if (shift_q != TAG_WAVE) begin
            failed = 1'b1;
            code   = ERR_WAVE;
          end else if (w.buffer_length < tag_q) begin
            failed = 1'b1;
            code   = ERR_RIFF_LEN;
          end else begin
            phase_q = PH_FMT;
          end
        end
      end
      PH_FMT: begin
        if (off == OFF_FMT_LEN) skip_q = shift_q;
        else if (off == OFF_FMT_CODE) tag_q = {16'h0000, shift_q[31:16]};
        else if (off == OFF_CHANNELS) tag_q = {shift_q[31:16], tag_q[15:0]};
        else if (off == OFF_RATE) rate_q = shift_q;
        else if (off == OFF_ALIGN) align_q = shift_q[31:16];
        else if (off == OFF_DEPTH) begin
          if (tag_q[15:0] != PCM_FORMAT) begin
            failed = 1'b1;
            code   = ERR_PCM;
          end else if (shift_q[31:16] != PCM_DEPTH) begin
            failed = 1'b1;
            code   = ERR_DEPTH;
          end else if (tag_q[31:16] != MONO) begin
            failed = 1'b1;
            code   = ERR_CHANNELS;
          end else if (skip_q < MIN_FMT_LEN) begin
            failed = 1'b1;
            code   = ERR_FMT_LEN;
          end else begin
            skip_q   = skip_q - MIN_FMT_LEN;
            offset_q = '0;
            phase_q  = (skip_q != 0) ? PH_SKIP : PH_CHDR;
          end
        end
      end
      PH_SKIP: begin
        skip_q = skip_q - 1;
        if (skip_q == 0) begin
          offset_q = '0;
          phase_q  = PH_CHDR;
        end
      end
      PH_CHDR: begin
        if (off == OFF_CHUNK_TAG) begin
          tag_q = shift_q;
        end else if (off >= OFF_CHUNK_LEN) begin
          offset_q = '0;
          if (tag_q == TAG_DATA) begin
            data_len_q   = shift_q;
            align_sum_q  = '0;
            fin          = !samples_left();
            r.kind       = KIND_FORMAT;
            r.rate       = rate_q;
            r.data_bytes = data_len_q;
            r.is_last    = fin;
            got          = 1'b1;
            phase_q      = fin ? PH_DONE : PH_SAMP;
          end else if (tag_q == TAG_FACT && shift_q != FACT_LEN) begin
            failed = 1'b1;
            code   = ERR_FACT;
          end else begin
            skip_q  = shift_q;
            phase_q = (shift_q != 0) ? PH_SKIP : PH_CHDR;
          end
        end
      end
      PH_SAMP: begin
        if (off == OFF_START) begin
          low_q = w.in_byte;
        end else begin
          offset_q    = '0;
          align_sum_q = align_sum_q + align_q;
          fin         = !samples_left();
          r.kind      = KIND_SAMPLE;
          r.sample    = {w.in_byte, low_q};
          r.is_last   = fin;
          got         = 1'b1;
          if (fin) phase_q = PH_DONE;
        end
      end
      default: ;
    endcase
    if (failed) begin
      r       = error_word(code);
      got     = 1'b1;
      phase_q = PH_DONE;
    end
    if (w.end_of_buffer) begin
      if (phase_q != PH_DONE) begin
        r   = error_word(ERR_TRUNCATED);
        got = 1'b1;
      end
      clear_parser();
    end
  endtask

  function automatic logic word_differs(wps_out_t want, wps_out_t seen);
    return (want.kind !== seen.kind) || (want.sample !== seen.sample) ||
           (want.rate !== seen.rate) || (want.data_bytes !== seen.data_bytes) ||
           (want.error_code !== seen.error_code) || (want.is_last !== seen.is_last);
  endfunction

  task automatic flag(string what, wps_out_t want, wps_out_t seen);
    fails++;
    if (fails <= REPORT_LIMIT) begin
      $display("%s at %0t: expected kind %0d sample %0d rate %h bytes %h code %0d last %0b",
               what, $time, want.kind, want.sample, want.rate, want.data_bytes,
               want.error_code, want.is_last);
      $display("    got kind %0d sample %0d rate %h bytes %h code %0d last %0b",
               seen.kind, seen.sample, seen.rate, seen.data_bytes, seen.error_code,
               seen.is_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic     got;
    wps_out_t predicted;
    wps_out_t want;
    if (!rst_ni) begin
      clear_parser();
      due_results.delete();
      fails   = 0;
      formats = 0;
      samples = 0;
      errors  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_word_i, got, predicted);
        if (got) due_results.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        case (out_word_i.kind)
          KIND_FORMAT: formats++;
          KIND_SAMPLE: samples++;
          default:     errors++;
        endcase
        if (due_results.size() == 0) begin
          flag("Unexpected word", '0, out_word_i);
        end else begin
          want = due_results.pop_front();
          if (word_differs(want, out_word_i)) flag("Mismatch", want, out_word_i);
        end
      end
    end
    pending_o     <= due_results.size();
    fail_count_o  <= fails;
    format_seen_o <= formats;
    sample_seen_o <= samples;
    error_seen_o  <= errors;
  end

endmodule

// File: tb/testbench.sv
// Testbench top: feeds byte buffers to the WAVE parser and reports the verdict.
`timescale 1ns / 1ps

module testbench;
  import wps_pkg::*;

  // Buffer shapes. Bar truncation and noise, each failure shape is a well-formed
  // buffer with one field broken, so the parse reaches that check before it fails.
  typedef enum int {
    BUF_SHORT,
    BUF_RIFF_TAG,
    BUF_WAVE_TAG,
    BUF_RIFF_LEN,
    BUF_PCM,
    BUF_DEPTH,
    BUF_CHANNELS,
    BUF_FMT_LEN,
    BUF_FACT,
    BUF_TRUNCATED,
    BUF_NOISE,
    BUF_GOOD
  } buf_mode_e;

  localparam int          MODE_COUNT    = 12;
  localparam int unsigned RANDOM_BYTES  = 1150;
  localparam int unsigned MAX_IDLE      = 18;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6d66;
  localparam logic [31:0] TAG_LIST      = 32'h5453_494c;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  wps_in_t     in_word  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wps_out_t    out_word;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned format_seen;
  int unsigned sample_seen;
  int unsigned error_seen;

  // When calm is set, neither side idles, which gives back-to-back stretches.
  logic        calm     = 1'b0;
  int unsigned out_hold = 0;

  // The buffer under construction and the length that travels with each byte.
  logic [7:0]  wave_q[$];
  logic [31:0] wave_len;
  int unsigned bytes_sent   = 0;
  int unsigned buffers_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wav_pcm16_mono_stream_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  wave_parse_checker result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .format_seen_o (format_seen),
    .sample_seen_o (sample_seen),
    .error_seen_o  (error_seen)
  );

  // Number of idle cycles drawn before a word: mostly short, sometimes long.
  function automatic int unsigned idle_cycles();
    int unsigned n;
    n = 0;
    if (!calm) begin
      case ($urandom_range(0, 2))
        0:       n = 0;
        1:       n = $urandom_range(0, 3);
        default: n = $urandom_range(0, MAX_IDLE);
      endcase
    end
    return n;
  endfunction

  // Output side. After every accepted word the receiver draws how long it
  // stalls before it takes the next one. The stall runs whether or not a word
  // is waiting, so it lands on every phase of the parse.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_hold = idle_cycles();
      else if (out_hold != 0) out_hold--;
      out_stall <= (out_hold != 0);
    end
  end

  task automatic push16(logic [15:0] v);
    wave_q.push_back(v[7:0]);
    wave_q.push_back(v[15:8]);
  endtask

  task automatic push32(logic [31:0] v);
    push16(v[15:0]);
    push16(v[31:16]);
  endtask

  function automatic logic [15:0] other16(logic [15:0] good);
    logic [15:0] v;
    v = 16'($urandom);
    if (v == good) v = ~good;
    return v;
  endfunction

  function automatic logic [31:0] corrupt32(logic [31:0] good);
    logic [31:0] mask;
    mask = $urandom;
    if (mask == 0) mask = 32'd1;
    return good ^ mask;
  endfunction

  // One chunk between the fmt chunk and the data chunk. A broken fact chunk
  // carries a size up to nine but not four, and the parse has to stop on it.
  task automatic add_chunk(logic bad_fact);
    logic [31:0] size;
    if (bad_fact) begin
      size = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(5, 9);
      push32(TAG_FACT);
    end else if ($urandom_range(0, 1) == 0) begin
      size = FACT_LEN;
      push32(TAG_FACT);
    end else begin
      size = $urandom_range(0, 6);
      push32(($urandom_range(0, 1) == 0) ? TAG_LIST : $urandom);
    end
    push32(size);
    repeat (size) wave_q.push_back(8'($urandom));
  endtask

  // Builds one buffer of the given shape in wave_q and sets wave_len.
  task automatic build_buffer(buf_mode_e mode);
    int unsigned n_ext;
    int unsigned n_data;
    int unsigned cut;
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    logic [31:0] riff_len;
    logic [15:0] align;
    wave_q.delete();
    if (mode == BUF_NOISE) begin
      repeat ($urandom_range(1, 12)) wave_q.push_back(8'($urandom));
      wave_len = $urandom;
      return;
    end
    n_ext   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    fmt_len = (mode == BUF_FMT_LEN) ? $urandom_range(0, 15) : MIN_FMT_LEN + n_ext;
    // Zero alignment means no samples at all; a huge one means the format
    // word closes the buffer as well.
    case ($urandom_range(0, 7))
      0:       align = 16'd0;
      1:       align = 16'd1;
      5:       align = 16'd4;
      6:       align = 16'd3;
      7:       align = 16'($urandom);
      default: align = 16'd2;
    endcase
    data_len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 24);

    push32((mode == BUF_RIFF_TAG) ? corrupt32(TAG_RIFF) : TAG_RIFF);
    push32('0);
    push32((mode == BUF_WAVE_TAG) ? corrupt32(TAG_WAVE) : TAG_WAVE);
    // The fmt tag itself is not checked by the parser, so it may be anything.
    push32(($urandom_range(0, 1) == 0) ? TAG_FMT : $urandom);
    push32(fmt_len);
    push16((mode == BUF_PCM) ? other16(PCM_FORMAT) : PCM_FORMAT);
    push16((mode == BUF_CHANNELS) ? other16(MONO) : MONO);
    push32($urandom);
    push32($urandom);
    push16(align);
    push16((mode == BUF_DEPTH) ? other16(PCM_DEPTH) : PCM_DEPTH);
    repeat (n_ext) wave_q.push_back(8'($urandom));

    repeat ($urandom_range(0, 2)) add_chunk(1'b0);
    if (mode == BUF_FACT) add_chunk(1'b1);

    push32(TAG_DATA);
    push32(data_len);
    // With an alignment of one each two-byte sample only advances the sum by
    // one, so twice the bytes are needed to reach the end of the data.
    if (data_len <= 32) n_data = (align == 16'd1) ? 2 * data_len : data_len;
    else n_data = $urandom_range(0, 20);
    repeat (n_data) wave_q.push_back(8'($urandom));
    // Trailing bytes after the last sample must be ignored.
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 4)) wave_q.push_back(8'($urandom));
    end

    wave_len = wave_q.size();
    riff_len = wave_len - 8;
    if (mode == BUF_SHORT) begin
      wave_len = $urandom_range(0, MIN_HEADER - 1);
    end else if (mode == BUF_RIFF_LEN) begin
      riff_len = wave_len + $urandom_range(1, 32'h7FFF_FFFF);
    end else if ($urandom_range(0, 3) == 0) begin
      // A claimed length far beyond the bytes sent exercises its upper bits.
      wave_len = $urandom;
      if (wave_len < MIN_HEADER) wave_len = wave_len + MIN_HEADER;
      riff_len = $urandom_range(0, wave_len);
    end
    for (int i = 0; i < 4; i++) wave_q[4 + i] = riff_len[8 * i +: 8];

    if (mode == BUF_TRUNCATED) begin
      cut = $urandom_range(1, wave_q.size() - 1);
      while (wave_q.size() > cut) void'(wave_q.pop_back());
    end
  endtask

  // Offers one word and holds it until it is accepted.
  task automatic send_byte(wps_in_t w);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    wps_in_t w;
    foreach (wave_q[i]) begin
      w.in_byte       = wave_q[i];
      w.end_of_buffer = (i == wave_q.size() - 1);
      w.buffer_length = wave_len;
      send_byte(w);
    end
    buffers_sent++;
  endtask

  // Stops sending until every predicted word has come out. The pending count
  // is registered in the checker, so the task waits on the clock before reading it.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned start;
    buf_mode_e   mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed buffers. A single byte whose claimed length is too short,
    // once at zero and once just under the minimum.
    wave_q   = '{8'hFF};
    wave_len = '0;
    send_buffer();
    wave_q   = '{8'h00};
    wave_len = MIN_HEADER - 1;
    send_buffer();
    // A wrong RIFF tag that ends the buffer on the failing byte.
    wave_q.delete();
    push32({8'h58, TAG_RIFF[23:0]});
    wave_len = MIN_HEADER;
    send_buffer();
    // A buffer cut off inside the RIFF tag, with the largest claimed length.
    wave_q   = '{TAG_RIFF[7:0], TAG_RIFF[15:8], TAG_RIFF[23:16]};
    wave_len = '1;
    send_buffer();
    // A RIFF length that is larger than the whole buffer.
    wave_q.delete();
    push32(TAG_RIFF);
    push32('1);
    push32(TAG_WAVE);
    wave_len = MIN_HEADER;
    send_buffer();
    // A lone first byte that passes the length check and then ends.
    wave_q   = '{8'h00};
    wave_len = MIN_HEADER;
    send_buffer();
    drain();

    // Random buffers. The first ones walk through every shape once; after
    // that half are well formed and the rest take a shape drawn at random.
    n     = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      if (n < MODE_COUNT) mode = buf_mode_e'(n);
      else if ($urandom_range(0, 1) != 0) mode = BUF_GOOD;
      else mode = buf_mode_e'($urandom_range(0, MODE_COUNT - 1));
      build_buffer(mode);
      send_buffer();
      if ($urandom_range(0, 5) == 0) drain();
      n++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers, every header failure and truncation among them.",
             bytes_sent, buffers_sent);
    $display("Compared %0d format, %0d sample and %0d error words with the predicted parse.",
             format_seen, sample_seen, error_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Generous limit on the whole run, far above the slowest correct one.
  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
